// ===== rtl/core/slq_pkg.sv =====
// shared types and constants for the searchable linear queue
`timescale 1ns / 1ps
package slq_pkg;

    // request command codes
    typedef enum logic [3:0] {
        CMD_ENQ     = 4'd0,
        CMD_DEQ     = 4'd1,
        CMD_SEARCH  = 4'd2,
        CMD_COUNT   = 4'd3,
        CMD_MAXKIND = 4'd4,
        CMD_CNTKIND = 4'd5,
        CMD_SUMKIND = 4'd6,
        CMD_REVERSE = 4'd7,
        CMD_ORDER   = 4'd8,
        CMD_CLEAR   = 4'd9
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DEQ_RD,
        S_DEQ_CAP,
        S_SCAN,
        S_REV_CHK,
        S_REV_RD_HI,
        S_REV_WR_LO,
        S_REV_WR_HI,
        S_FIN
    } t_state;

    localparam int unsigned TOTAL_W = 40;

    // one stored record
    typedef struct packed {
        logic signed [31:0] code;
        logic [1:0]         kind;
        logic [31:0]        amount;
    } t_rec;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic dispatch;
        logic scan;
        logic deq_cap;
        logic rev_start;
        logic rev_rd_hi;
        logic rev_wr_lo;
        logic rev_wr_hi;
        logic finish;
    } t_ctrl;

    // status from datapath to controller
    typedef struct packed {
        logic [3:0] cmd;
        logic       empty;
        logic       scan_done;
        logic       rev_more;
        logic       out_free;
    } t_stat;

endpackage

// ===== rtl/core/slq_req_if.sv =====
// request channel interface
`timescale 1ns / 1ps
interface slq_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         command;
    logic signed [31:0] item_code;
    logic [1:0]         item_kind;
    logic [31:0]        item_amount;

    modport source (output valid, command, item_code, item_kind, item_amount, input ready);
    modport sink (input valid, command, item_code, item_kind, item_amount, output ready);
endinterface

// ===== rtl/core/slq_rsp_if.sv =====
// result channel interface
`timescale 1ns / 1ps
interface slq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] result_code;
    logic [1:0]         result_kind;
    logic [31:0]        result_amount;
    logic [6:0]         slot_index;
    logic [6:0]         queue_position;
    logic [7:0]         tally;
    logic [39:0]        total;
    logic               in_order;

    modport source (output valid, status, result_code, result_kind, result_amount,
                    slot_index, queue_position, tally, total, in_order, input ready);
    modport sink (input valid, status, result_code, result_kind, result_amount,
                  slot_index, queue_position, tally, total, in_order, output ready);
endinterface

// ===== rtl/core/slq_ctrl.sv =====
// sequencing state machine for the searchable linear queue
`timescale 1ns / 1ps
module slq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  slq_pkg::t_stat i_stat,
    output logic           o_ready,
    output slq_pkg::t_ctrl o_ctrl
);

    slq_pkg::t_state r_state;
    slq_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            slq_pkg::S_IDLE: begin
                if (i_valid) n_state = slq_pkg::S_DISPATCH;
            end
            slq_pkg::S_DISPATCH: begin
                case (i_stat.cmd)
                    slq_pkg::CMD_DEQ:
                        n_state = i_stat.empty ? slq_pkg::S_FIN : slq_pkg::S_DEQ_RD;
                    slq_pkg::CMD_MAXKIND:
                        n_state = i_stat.empty ? slq_pkg::S_FIN : slq_pkg::S_SCAN;
                    slq_pkg::CMD_SEARCH, slq_pkg::CMD_CNTKIND,
                    slq_pkg::CMD_SUMKIND, slq_pkg::CMD_ORDER:
                        n_state = slq_pkg::S_SCAN;
                    slq_pkg::CMD_REVERSE:
                        n_state = slq_pkg::S_REV_CHK;
                    default:
                        n_state = slq_pkg::S_FIN;
                endcase
            end
            slq_pkg::S_DEQ_RD:    n_state = slq_pkg::S_DEQ_CAP;
            slq_pkg::S_DEQ_CAP:   n_state = slq_pkg::S_FIN;
            slq_pkg::S_SCAN: begin
                if (i_stat.scan_done) n_state = slq_pkg::S_FIN;
            end
            slq_pkg::S_REV_CHK: begin
                n_state = i_stat.rev_more ? slq_pkg::S_REV_RD_HI : slq_pkg::S_FIN;
            end
            slq_pkg::S_REV_RD_HI: n_state = slq_pkg::S_REV_WR_LO;
            slq_pkg::S_REV_WR_LO: n_state = slq_pkg::S_REV_WR_HI;
            slq_pkg::S_REV_WR_HI: n_state = slq_pkg::S_REV_CHK;
            slq_pkg::S_FIN: begin
                if (i_stat.out_free) n_state = slq_pkg::S_IDLE;
            end
            default:              n_state = slq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl  = '0;
        o_ready = 1'b0;
        case (r_state)
            slq_pkg::S_IDLE: begin
                o_ready     = 1'b1;
                o_ctrl.load = i_valid;
            end
            slq_pkg::S_DISPATCH:  o_ctrl.dispatch  = 1'b1;
            slq_pkg::S_DEQ_CAP:   o_ctrl.deq_cap   = 1'b1;
            slq_pkg::S_SCAN:      o_ctrl.scan      = 1'b1;
            slq_pkg::S_REV_CHK:   o_ctrl.rev_start = i_stat.rev_more;
            slq_pkg::S_REV_RD_HI: o_ctrl.rev_rd_hi = 1'b1;
            slq_pkg::S_REV_WR_LO: o_ctrl.rev_wr_lo = 1'b1;
            slq_pkg::S_REV_WR_HI: o_ctrl.rev_wr_hi = 1'b1;
            slq_pkg::S_FIN:       o_ctrl.finish    = i_stat.out_free;
            default:              o_ctrl           = '0;
        endcase
    end

`ifndef SYNTHESIS
    // a request is taken only when idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load |-> r_state == slq_pkg::S_IDLE)
        else $error("load outside idle");
    // a load is always followed by dispatch
    a_load_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load |=> o_ctrl.dispatch)
        else $error("dispatch missing after load");
    // a finished result returns the controller to idle
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.finish |=> o_ready)
        else $error("not idle after finish");
`endif

endmodule

// ===== rtl/core/slq_dp.sv =====
// record store, pointers, scan accumulators and result register
`timescale 1ns / 1ps
module slq_dp #(
    parameter int unsigned DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slq_pkg::t_ctrl     i_ctrl,
    output slq_pkg::t_stat     o_stat,
    input  logic [3:0]         i_command,
    input  logic signed [31:0] i_item_code,
    input  logic [1:0]         i_item_kind,
    input  logic [31:0]        i_item_amount,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_result_code,
    output logic [1:0]         o_result_kind,
    output logic [31:0]        o_result_amount,
    output logic [6:0]         o_slot_index,
    output logic [6:0]         o_queue_position,
    output logic [7:0]         o_tally,
    output logic [39:0]        o_total,
    output logic               o_in_order
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned PW = $clog2(DEPTH + 1);
    localparam int unsigned TW = slq_pkg::TOTAL_W;
    localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

    slq_pkg::t_rec r_mem [DEPTH];
    slq_pkg::t_rec r_rd_data;
    slq_pkg::t_rec r_item;
    slq_pkg::t_rec r_best;
    slq_pkg::t_rec r_tmp;
    logic [3:0]    r_cmd;
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [PW-1:0] r_idx;
    logic [PW-1:0] r_hi;
    logic [PW-1:0] r_rd_idx;
    logic [PW-1:0] r_match;
    logic [PW-1:0] r_cnt;
    logic [TW-1:0] r_sum;
    logic          r_rd_vld;
    logic          r_found;
    logic          r_in_order;
    logic signed [31:0] r_prev;
    logic [1:0]    r_status;

    logic          empty;
    logic          full;
    logic          issue;
    logic [PW-1:0] rd_ptr;
    logic          wr_en;
    logic [PW-1:0] wr_ptr;
    slq_pkg::t_rec wr_data;
    logic [TW:0]   sum_ext;
    logic          kind_hit;

    assign empty = r_head == r_tail;
    assign full  = r_tail >= DEPTH_P;
    assign issue = i_ctrl.scan && (r_idx != r_tail);

    // status to controller
    assign o_stat.cmd       = r_cmd;
    assign o_stat.empty     = empty;
    assign o_stat.scan_done = (r_idx == r_tail) && !r_rd_vld;
    assign o_stat.rev_more  = {1'b0, r_hi} > ({1'b0, r_idx} + (PW+1)'(1));
    assign o_stat.out_free  = !o_out_valid || i_out_ready;

    // memory port selection
    assign rd_ptr = i_ctrl.rev_rd_hi ? r_hi : r_idx;
    always_comb begin
        wr_en   = 1'b0;
        wr_ptr  = r_tail;
        wr_data = r_item;
        if (i_ctrl.dispatch && (r_cmd == slq_pkg::CMD_ENQ) && !full) begin
            wr_en = 1'b1;
        end else if (i_ctrl.rev_wr_lo) begin
            wr_en   = 1'b1;
            wr_ptr  = r_idx;
            wr_data = r_rd_data;
        end else if (i_ctrl.rev_wr_hi) begin
            wr_en   = 1'b1;
            wr_ptr  = r_hi;
            wr_data = r_tmp;
        end
    end

    // record memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_ptr[AW-1:0]] <= wr_data;
        r_rd_data <= r_mem[rd_ptr[AW-1:0]];
    end

    // pointers and scan valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (wr_en && i_ctrl.dispatch) r_tail <= r_tail + PW'(1);
            if (i_ctrl.deq_cap) r_head <= r_head + PW'(1);
            if (i_ctrl.dispatch && (r_cmd == slq_pkg::CMD_CLEAR)) begin
                r_head <= '0;
                r_tail <= '0;
            end
        end
    end

    assign kind_hit = r_rd_data.kind == r_item.kind;
    assign sum_ext  = {1'b0, r_sum} + (TW+1)'(r_rd_data.amount);

    // command working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd       <= i_command;
            r_item.code <= i_item_code;
            r_item.kind <= i_item_kind;
            r_item.amount <= i_item_amount;
            r_idx       <= r_head;
            r_hi        <= r_tail;
            r_status    <= slq_pkg::ST_OK;
            r_found     <= 1'b0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_in_order  <= 1'b1;
        end
        if (i_ctrl.dispatch) begin
            case (r_cmd)
                slq_pkg::CMD_ENQ: begin
                    if (full) r_status <= slq_pkg::ST_FULL;
                end
                slq_pkg::CMD_DEQ, slq_pkg::CMD_MAXKIND: begin
                    if (empty) r_status <= slq_pkg::ST_EMPTY;
                end
                default: ;
            endcase
        end
        if (i_ctrl.deq_cap) r_best <= r_rd_data;
        // walk of the stored span
        if (issue) begin
            r_idx    <= r_idx + PW'(1);
            r_rd_idx <= r_idx;
        end
        if (r_rd_vld) begin
            r_prev <= r_rd_data.code;
            case (r_cmd)
                slq_pkg::CMD_SEARCH: begin
                    if (!r_found && (r_rd_data.code == r_item.code)) begin
                        r_found <= 1'b1;
                        r_match <= r_rd_idx;
                    end
                end
                slq_pkg::CMD_MAXKIND: begin
                    if (kind_hit && (!r_found || (r_rd_data.amount > r_best.amount))) begin
                        r_found <= 1'b1;
                        r_best  <= r_rd_data;
                    end
                end
                slq_pkg::CMD_CNTKIND: begin
                    if (kind_hit) r_cnt <= r_cnt + PW'(1);
                end
                slq_pkg::CMD_SUMKIND: begin
                    if (kind_hit) r_sum <= sum_ext[TW] ? '1 : sum_ext[TW-1:0];
                end
                slq_pkg::CMD_ORDER: begin
                    if ((r_rd_idx != r_head) && (r_prev > r_rd_data.code)) r_in_order <= 1'b0;
                end
                default: ;
            endcase
        end
        // in-place swap
        if (i_ctrl.rev_start) r_hi <= r_hi - PW'(1);
        if (i_ctrl.rev_rd_hi) r_tmp <= r_rd_data;
        if (i_ctrl.rev_wr_hi) r_idx <= r_idx + PW'(1);
    end

    // result assembly
    logic [1:0]    fin_status;
    logic          fin_rec;
    logic [31:0]   match_w;
    logic [31:0]   pos_w;
    logic [31:0]   tally_w;
    always_comb begin
        fin_status = r_status;
        fin_rec    = 1'b0;
        tally_w    = '0;
        match_w    = 32'(r_match);
        pos_w      = 32'(r_match - r_head);
        case (r_cmd)
            slq_pkg::CMD_SEARCH: fin_status = r_found ? slq_pkg::ST_OK : slq_pkg::ST_NOTFOUND;
            slq_pkg::CMD_MAXKIND: begin
                if (r_status == slq_pkg::ST_OK) begin
                    fin_status = r_found ? slq_pkg::ST_OK : slq_pkg::ST_NOTFOUND;
                    fin_rec    = r_found;
                end
            end
            slq_pkg::CMD_DEQ:     fin_rec = r_status == slq_pkg::ST_OK;
            slq_pkg::CMD_COUNT:   tally_w = 32'(r_tail - r_head);
            slq_pkg::CMD_CNTKIND: tally_w = 32'(r_cnt);
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_ctrl.finish) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.finish) begin
            o_status         <= fin_status;
            o_result_code    <= fin_rec ? r_best.code : '0;
            o_result_kind    <= fin_rec ? r_best.kind : '0;
            o_result_amount  <= fin_rec ? r_best.amount : '0;
            o_slot_index     <= (r_cmd == slq_pkg::CMD_SEARCH && r_found) ? match_w[6:0] : '0;
            o_queue_position <= (r_cmd == slq_pkg::CMD_SEARCH && r_found) ? pos_w[6:0] : '0;
            o_tally          <= tally_w[7:0];
            o_total          <= (r_cmd == slq_pkg::CMD_SUMKIND) ? r_sum : '0;
            o_in_order       <= (r_cmd == slq_pkg::CMD_ORDER) ? r_in_order : 1'b0;
        end
    end

`ifndef SYNTHESIS
    // head never passes tail
    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("head beyond tail");
    // tail never goes beyond the store depth
    a_tail_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= DEPTH_P)
        else $error("tail beyond depth");
    // a finished result is not overwritten while still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.finish |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten");
    // span walk stays below tail
    a_scan_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> r_rd_idx < r_tail)
        else $error("scan read outside span");
`endif

endmodule

// ===== rtl/core/searchable_linear_queue.sv =====
// top level of the searchable linear queue
//
//  channel  dir  handshake      payload
//  i_req    in   valid/ready    command, item_code, item_kind, item_amount
//  o_rsp    out  valid/ready    status, result record, slot, position, tally, total, in_order
//
// one request at a time; enqueue, count and clear go from dispatch straight to the result
// dequeue reads the head record; search, kind queries, order check walk all stored entries
// reverse swaps one pair at a time, bound by the single write port of the record store
// reset (synchronous, active low) empties the queue; store contents stay undefined
// a result waiting on o_rsp stalls only the completion of the next request
`timescale 1ns / 1ps
module searchable_linear_queue #(
    parameter int unsigned DEPTH = 128
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    slq_req_if.sink  i_req,
    slq_rsp_if.source o_rsp
);

    slq_pkg::t_ctrl ctrl;
    slq_pkg::t_stat stat;

    // sequencer
    slq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_stat  (stat),
        .o_ready (i_req.ready),
        .o_ctrl  (ctrl)
    );

    // store and result datapath
    slq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .o_stat           (stat),
        .i_command        (i_req.command),
        .i_item_code      (i_req.item_code),
        .i_item_kind      (i_req.item_kind),
        .i_item_amount    (i_req.item_amount),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_result_code    (o_rsp.result_code),
        .o_result_kind    (o_rsp.result_kind),
        .o_result_amount  (o_rsp.result_amount),
        .o_slot_index     (o_rsp.slot_index),
        .o_queue_position (o_rsp.queue_position),
        .o_tally          (o_rsp.tally),
        .o_total          (o_rsp.total),
        .o_in_order       (o_rsp.in_order)
    );

endmodule

// ===== dv/tb_searchable_linear_queue.sv =====
// self-checking testbench for the searchable linear queue
`timescale 1ns / 1ps
module tb_searchable_linear_queue;

    localparam int unsigned QDEPTH = 128;
    localparam longint unsigned SUM_MAX = 64'hFF_FFFF_FFFF;
    localparam int unsigned LIMIT = 1500000;

    // one request on the input channel
    typedef struct {
        logic [3:0]         command;
        logic signed [31:0] item_code;
        logic [1:0]         item_kind;
        logic [31:0]        item_amount;
    } t_req;

    // one expected result
    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] result_code;
        logic [1:0]         result_kind;
        logic [31:0]        result_amount;
        logic [6:0]         slot_index;
        logic [6:0]         queue_position;
        logic [7:0]         tally;
        logic [39:0]        total;
        logic               in_order;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    slq_req_if req_ch ();
    slq_rsp_if rsp_ch ();

    searchable_linear_queue #(.DEPTH(QDEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // shadow copy of the queue
    logic signed [31:0] shadow_code [QDEPTH];
    logic [1:0]         shadow_kind [QDEPTH];
    logic [31:0]        shadow_amount [QDEPTH];
    int unsigned        shadow_head;
    int unsigned        shadow_tail;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];

    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned accepted_count;
    int unsigned result_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_cycles;
    logic        send_pause;

    // work out the result of one request and update the shadow queue
    function automatic t_rsp predict_queue_result(t_req rq);
        t_rsp r;
        int unsigned i, lo, hi, best;
        bit found;
        longint unsigned acc;
        logic signed [31:0] tc;
        logic [1:0] tk;
        logic [31:0] ta;
        r = '{default: '0};
        case (rq.command)
            slq_pkg::CMD_ENQ: begin
                if (shadow_tail >= QDEPTH) begin
                    r.status = slq_pkg::ST_FULL;
                end else begin
                    shadow_code[shadow_tail] = rq.item_code;
                    shadow_kind[shadow_tail] = rq.item_kind;
                    shadow_amount[shadow_tail] = rq.item_amount;
                    shadow_tail++;
                end
            end
            slq_pkg::CMD_DEQ: begin
                if (shadow_head == shadow_tail) begin
                    r.status = slq_pkg::ST_EMPTY;
                end else begin
                    r.result_code = shadow_code[shadow_head];
                    r.result_kind = shadow_kind[shadow_head];
                    r.result_amount = shadow_amount[shadow_head];
                    shadow_head++;
                end
            end
            slq_pkg::CMD_SEARCH: begin
                r.status = slq_pkg::ST_NOTFOUND;
                for (i = shadow_head; i < shadow_tail; i++) begin
                    if (shadow_code[i] == rq.item_code) begin
                        r.status = slq_pkg::ST_OK;
                        r.slot_index = i[6:0];
                        r.queue_position = 7'(i - shadow_head);
                        break;
                    end
                end
            end
            slq_pkg::CMD_COUNT: r.tally = 8'(shadow_tail - shadow_head);
            slq_pkg::CMD_MAXKIND: begin
                found = 1'b0;
                best = 0;
                if (shadow_head == shadow_tail) begin
                    r.status = slq_pkg::ST_EMPTY;
                end else begin
                    for (i = shadow_head; i < shadow_tail; i++) begin
                        if (shadow_kind[i] == rq.item_kind &&
                            (!found || shadow_amount[i] > shadow_amount[best])) begin
                            best = i;
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        r.status = slq_pkg::ST_NOTFOUND;
                    end else begin
                        r.result_code = shadow_code[best];
                        r.result_kind = shadow_kind[best];
                        r.result_amount = shadow_amount[best];
                    end
                end
            end
            slq_pkg::CMD_CNTKIND: begin
                for (i = shadow_head; i < shadow_tail; i++)
                    if (shadow_kind[i] == rq.item_kind) r.tally++;
            end
            slq_pkg::CMD_SUMKIND: begin
                acc = 0;
                for (i = shadow_head; i < shadow_tail; i++) begin
                    if (shadow_kind[i] == rq.item_kind) begin
                        acc += shadow_amount[i];
                        if (acc > SUM_MAX) acc = SUM_MAX;
                    end
                end
                r.total = acc[39:0];
            end
            slq_pkg::CMD_REVERSE: begin
                lo = shadow_head;
                hi = shadow_tail;
                while (hi > lo + 1) begin
                    hi--;
                    tc = shadow_code[lo]; shadow_code[lo] = shadow_code[hi]; shadow_code[hi] = tc;
                    tk = shadow_kind[lo]; shadow_kind[lo] = shadow_kind[hi]; shadow_kind[hi] = tk;
                    ta = shadow_amount[lo];
                    shadow_amount[lo] = shadow_amount[hi];
                    shadow_amount[hi] = ta;
                    lo++;
                end
            end
            slq_pkg::CMD_ORDER: begin
                r.in_order = 1'b1;
                for (i = shadow_head; i + 1 < shadow_tail; i++) begin
                    if (shadow_code[i] > shadow_code[i + 1]) begin
                        r.in_order = 1'b0;
                        break;
                    end
                end
            end
            slq_pkg::CMD_CLEAR: begin
                shadow_head = 0;
                shadow_tail = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 result_count, what, got, want);
        mismatch_count++;
    endtask

    function automatic t_req make_req(logic [3:0] c, logic [31:0] code,
                                      logic [1:0] k, logic [31:0] amt);
        t_req rq;
        rq.command = c;
        rq.item_code = code;
        rq.item_kind = k;
        rq.item_amount = amt;
        return rq;
    endfunction

    // random request, weighted toward enqueue with small codes so searches hit
    function automatic t_req rand_req();
        int unsigned pick;
        logic [3:0] c;
        logic [31:0] code, amt;
        pick = $urandom_range(99);
        if (pick < 40) c = slq_pkg::CMD_ENQ;
        else if (pick < 52) c = slq_pkg::CMD_DEQ;
        else if (pick < 60) c = slq_pkg::CMD_SEARCH;
        else if (pick < 64) c = slq_pkg::CMD_COUNT;
        else if (pick < 70) c = slq_pkg::CMD_MAXKIND;
        else if (pick < 75) c = slq_pkg::CMD_CNTKIND;
        else if (pick < 81) c = slq_pkg::CMD_SUMKIND;
        else if (pick < 86) c = slq_pkg::CMD_REVERSE;
        else if (pick < 92) c = slq_pkg::CMD_ORDER;
        else if (pick < 95) c = slq_pkg::CMD_CLEAR;
        else c = 4'($urandom_range(15, 10));
        code = ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(40)) - 20);
        amt = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(50));
        return make_req(c, code, 2'($urandom_range(3)), amt);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() > 0 && !send_pause &&
                $urandom_range(99) >= send_idle_pct) begin
                t_req rq;
                rq = pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.command <= rq.command;
                req_ch.item_code <= rq.item_code;
                req_ch.item_kind <= rq.item_kind;
                req_ch.item_amount <= rq.item_amount;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(predict_queue_result(make_req(req_ch.command,
                req_ch.item_code, req_ch.item_kind, req_ch.item_amount)));
            accepted_count++;
        end
    end

    // receiver stalls; a long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            t_rsp e;
            result_count++;
            if (expected_rsps.size() == 0) begin
                $display("unexpected result %0d", result_count);
                mismatch_count++;
            end else begin
                e = expected_rsps.pop_front();
                if (rsp_ch.status !== e.status)
                    report_mismatch("status", rsp_ch.status, e.status);
                if (rsp_ch.result_code !== e.result_code)
                    report_mismatch("result_code", 32'(rsp_ch.result_code), 32'(e.result_code));
                if (rsp_ch.result_kind !== e.result_kind)
                    report_mismatch("result_kind", rsp_ch.result_kind, e.result_kind);
                if (rsp_ch.result_amount !== e.result_amount)
                    report_mismatch("result_amount", rsp_ch.result_amount, e.result_amount);
                if (rsp_ch.slot_index !== e.slot_index)
                    report_mismatch("slot_index", rsp_ch.slot_index, e.slot_index);
                if (rsp_ch.queue_position !== e.queue_position)
                    report_mismatch("queue_position", rsp_ch.queue_position, e.queue_position);
                if (rsp_ch.tally !== e.tally)
                    report_mismatch("tally", rsp_ch.tally, e.tally);
                if (rsp_ch.total !== e.total)
                    report_mismatch("total", rsp_ch.total, e.total);
                if (rsp_ch.in_order !== e.in_order)
                    report_mismatch("in_order", rsp_ch.in_order, e.in_order);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
    endtask

    // stimulus and phase control
    initial begin
        int unsigned n, p;
        cycle_count = 0;
        mismatch_count = 0;
        accepted_count = 0;
        result_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        send_pause = 1'b0;
        shadow_head = 0;
        shadow_tail = 0;
        req_ch.valid = 1'b0;
        req_ch.command = slq_pkg::CMD_COUNT;
        req_ch.item_code = '0;
        req_ch.item_kind = '0;
        req_ch.item_amount = '0;
        rsp_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty cases, extremes, ties, every command
        pending_reqs.push_back(make_req(slq_pkg::CMD_DEQ, 0, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_MAXKIND, 0, 1, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_ORDER, 0, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_REVERSE, 0, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_SEARCH, 5, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_ENQ, 32'h7FFF_FFFF, 3, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(slq_pkg::CMD_ORDER, 0, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_ENQ, 32'h8000_0000, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_ENQ, 7, 3, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(slq_pkg::CMD_ENQ, 9, 2, 100));
        pending_reqs.push_back(make_req(slq_pkg::CMD_MAXKIND, 0, 3, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_MAXKIND, 0, 1, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_SUMKIND, 0, 3, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_CNTKIND, 0, 1, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_SEARCH, 32'h8000_0000, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_ORDER, 0, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_REVERSE, 0, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_ORDER, 0, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_DEQ, 0, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_COUNT, 0, 0, 0));
        pending_reqs.push_back(make_req(4'd15, -1, 3, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(slq_pkg::CMD_CLEAR, 0, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_COUNT, 0, 0, 0));
        wait_drained();

        // fill to full with near-maximum kind 3 amounts for a large sum, then overflow
        for (n = 0; n < QDEPTH + 2; n++)
            pending_reqs.push_back(make_req(slq_pkg::CMD_ENQ, $urandom, 3,
                                            32'hFFFF_FFF0 + n[3:0]));
        pending_reqs.push_back(make_req(slq_pkg::CMD_SUMKIND, 0, 3, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_DEQ, 0, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_ENQ, 1, 1, 1));
        pending_reqs.push_back(make_req(slq_pkg::CMD_COUNT, 0, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_REVERSE, 0, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_SEARCH, 0, 0, 0));
        pending_reqs.push_back(make_req(slq_pkg::CMD_CLEAR, 0, 0, 0));
        // long receiver hold-off while requests keep coming
        hold_cycles = 300;
        wait_drained();

        // random phases with different idling
        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            for (n = 0; n < 60; n++) pending_reqs.push_back(rand_req());
            // sender pause midway until all results are back
            while (pending_reqs.size() > 30) @(posedge i_clk);
            send_pause = 1'b1;
            while (expected_rsps.size() > 0 || req_ch.valid) @(posedge i_clk);
            send_pause = 1'b0;
            wait_drained();
        end

        repeat (400) @(posedge i_clk);
        $display("covered %0d requests and %0d results: empty, full, large sums,",
                 accepted_count, result_count);
        $display("reversal, searches and order checks under four idling mixes");
        if (mismatch_count == 0 && expected_rsps.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== searchable_linear_queue.f =====
rtl/core/slq_pkg.sv
rtl/core/slq_req_if.sv
rtl/core/slq_rsp_if.sv
rtl/core/slq_ctrl.sv
rtl/core/slq_dp.sv
rtl/core/searchable_linear_queue.sv
dv/tb_searchable_linear_queue.sv
